// ===== rtl/rctc_pkg.sv =====
// shared types and constants for the rivet count turntable controller
// used by every module of the block, no dependencies

package rctc_pkg;

   localparam int unsigned TICKS_PER_SECOND_RESET = 5000;
   localparam int unsigned DEBOUNCE_TICKS_RESET   = 5;
   localparam int unsigned FRAME_DEPTH_DEFAULT    = 10;
   localparam int unsigned SECONDS_PER_MINUTE     = 60;
   localparam int unsigned ASCII_ZERO             = 48;

   localparam int unsigned STEADY_WIDTH = 4;
   localparam int unsigned SECONDS_WIDTH = 6;
   localparam int unsigned COUNT_WIDTH = 8;

   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;

   // configuration register indexes
   localparam logic CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic CSR_DEBOUNCE_TICKS   = 1'b1;

   // result event codes
   localparam logic [1:0] EV_OK     = 2'd0;
   localparam logic [1:0] EV_ERROR  = 2'd1;
   localparam logic [1:0] EV_TURN   = 2'd2;
   localparam logic [1:0] EV_TARGET = 2'd3;

   // decoded frame commands
   localparam logic [2:0] CMD_START  = 3'd0;
   localparam logic [2:0] CMD_STOP   = 3'd1;
   localparam logic [2:0] CMD_MODE1  = 3'd2;
   localparam logic [2:0] CMD_MODE2  = 3'd3;
   localparam logic [2:0] CMD_TARGET = 3'd4;
   localparam logic [2:0] CMD_ERROR  = 3'd5;

   typedef struct packed {
      logic       done;
      logic [2:0] code;
      logic [7:0] digit;
   } frame_cmd_type;

endpackage

// ===== rtl/rivet_count_turntable_controller_unit.sv =====
// top level of the rivet count turntable controller: item register, run state,
// result register; depends on rctc_pkg, rctc_debounce and rctc_frame
// an item is registered on accept, and its result passes from the item register into the result register
// throughput: one item per cycle, set by the single pass from item register to result
// register; a waiting result stalls the item register only when the consumer holds off
// reset: synchronous, active high; config returns to 5000 ticks and 5 debounce ticks

module rivet_count_turntable_controller_unit #(
   parameter int unsigned FRAME_DEPTH = rctc_pkg::FRAME_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], rivet_level[8], turn_level[9], zero fill
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // rivet_total[7:0], elapsed_seconds[13:8], zero fill
   output logic [1:0]  rsp_tuser,   // event_res
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import rctc_pkg::*;

   // configuration
   logic [15:0]             tps_ff;
   logic [STEADY_WIDTH-1:0] debounce_ff;

   // item register
   logic       item_valid_ff;
   logic       item_func_ff;
   logic [7:0] item_byte_ff;
   logic       item_rivet_ff, item_turn_ff;
   logic       advance;

   // run state
   logic [15:0]              prescale_ff, prescale_in;
   logic [SECONDS_WIDTH-1:0] seconds_ff, seconds_in;
   logic                     running_ff, running_in;
   logic                     mode_two_ff, mode_two_in;
   logic                     armed_ff, armed_in;
   logic [COUNT_WIDTH-1:0]   target_ff, target_in;
   logic [COUNT_WIDTH-1:0]   rivets_ff, rivets_in;
   logic [1:0]               edge_prev_ff, edge_prev_in;

   // result register
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_event_ff;
   logic [COUNT_WIDTH-1:0]   rsp_total_ff;
   logic [SECONDS_WIDTH-1:0] rsp_seconds_ff;
   logic                     res_valid;
   logic [1:0]               res_event;
   logic [COUNT_WIDTH-1:0]   res_total;
   logic [SECONDS_WIDTH-1:0] res_seconds;

   logic                     tick_en, byte_en;
   logic                     clean_rivet, clean_turn;
   frame_cmd_type            cmd;
   logic [15:0]              prescale_inc;
   logic [SECONDS_WIDTH-1:0] seconds_inc;
   logic                     rivet_edge, turn_edge;
   logic [COUNT_WIDTH-1:0]   rivets_next;

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign tick_en    = advance && !item_func_ff;
   assign byte_en    = advance && item_func_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff      <= 16'(TICKS_PER_SECOND_RESET);
         debounce_ff <= STEADY_WIDTH'(DEBOUNCE_TICKS_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_TICKS_PER_SECOND: tps_ff <= csr_wdata;
            CSR_DEBOUNCE_TICKS:   debounce_ff <= csr_wdata[STEADY_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_func_ff  <= req_tuser;
         item_byte_ff  <= req_tdata[7:0];
         item_rivet_ff <= req_tdata[8];
         item_turn_ff  <= req_tdata[9];
      end
   end

   rctc_debounce u_rivet_debounce (
      .clock          (clock),
      .reset          (reset),
      .enable         (tick_en),
      .raw            (item_rivet_ff),
      .debounce_ticks (debounce_ff),
      .clean_level    (clean_rivet)
   );

   rctc_debounce u_turn_debounce (
      .clock          (clock),
      .reset          (reset),
      .enable         (tick_en),
      .raw            (item_turn_ff),
      .debounce_ticks (debounce_ff),
      .clean_level    (clean_turn)
   );

   rctc_frame #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .enable  (byte_en),
      .rx_byte (item_byte_ff),
      .cmd     (cmd)
   );

   assign prescale_inc = prescale_ff + 1'b1;
   assign seconds_inc  = seconds_ff + 1'b1;
   assign rivet_edge   = clean_rivet && !edge_prev_ff[0];
   assign turn_edge    = clean_turn && !edge_prev_ff[1];
   assign rivets_next  = rivets_ff + COUNT_WIDTH'(rivet_edge);

   always_comb begin
      prescale_in  = prescale_ff;
      seconds_in   = seconds_ff;
      running_in   = running_ff;
      mode_two_in  = mode_two_ff;
      armed_in     = armed_ff;
      target_in    = target_ff;
      rivets_in    = rivets_ff;
      edge_prev_in = edge_prev_ff;
      res_valid    = 1'b0;
      res_event    = EV_OK;
      res_total    = '0;
      res_seconds  = '0;
      if (byte_en && cmd.done) begin
         res_valid = 1'b1;
         case (cmd.code)
            CMD_START: begin
               running_in = 1'b1;
            end
            CMD_STOP: begin
               rivets_in   = '0;
               seconds_in  = '0;
               running_in  = 1'b0;
               mode_two_in = 1'b0;
               armed_in    = 1'b0;
               target_in   = '0;
            end
            CMD_MODE1: begin
               mode_two_in = 1'b0;
               seconds_in  = '0;
               rivets_in   = '0;
               target_in   = '0;
            end
            CMD_MODE2: begin
               mode_two_in = 1'b1;
               armed_in    = 1'b0;
            end
            CMD_TARGET: begin
               if (mode_two_ff) begin
                  seconds_in = '0;
                  rivets_in  = '0;
                  target_in  = cmd.digit - COUNT_WIDTH'(ASCII_ZERO);
                  armed_in   = 1'b1;
               end else begin
                  res_event = EV_ERROR;
               end
            end
            default: begin
               res_event = EV_ERROR;
            end
         endcase
      end else if (tick_en) begin
         prescale_in = prescale_inc;
         if (prescale_inc == tps_ff) begin
            prescale_in = '0;
            if (running_ff) begin
               seconds_in = (seconds_inc >= SECONDS_WIDTH'(SECONDS_PER_MINUTE)) ?
                            '0 : seconds_inc;
            end
         end
         if (!running_ff) begin
            seconds_in = '0;
         end else begin
            edge_prev_in = {clean_turn, clean_rivet};
            rivets_in    = rivets_next;
            if ((mode_two_ff && armed_ff && rivets_next == target_ff) ||
                (!mode_two_ff && turn_edge)) begin
               res_valid   = 1'b1;
               res_seconds = seconds_in;
               if (mode_two_ff) begin
                  res_event = EV_TARGET;
               end else begin
                  res_event = EV_TURN;
                  res_total = rivets_next;
               end
               rivets_in   = '0;
               seconds_in  = '0;
               running_in  = 1'b0;
               mode_two_in = 1'b0;
               armed_in    = 1'b0;
               target_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff  <= '0;
         seconds_ff   <= '0;
         running_ff   <= 1'b0;
         mode_two_ff  <= 1'b0;
         armed_ff     <= 1'b0;
         target_ff    <= '0;
         rivets_ff    <= '0;
         edge_prev_ff <= 2'b11;
      end else begin
         prescale_ff  <= prescale_in;
         seconds_ff   <= seconds_in;
         running_ff   <= running_in;
         mode_two_ff  <= mode_two_in;
         armed_ff     <= armed_in;
         target_ff    <= target_in;
         rivets_ff    <= rivets_in;
         edge_prev_ff <= edge_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_event_ff   <= res_event;
         rsp_total_ff   <= res_total;
         rsp_seconds_ff <= res_seconds;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tdata  = {2'b00, rsp_seconds_ff, rsp_total_ff};

   a_seconds_range: assert property (@(posedge clock) disable iff (reset)
      seconds_ff < SECONDS_WIDTH'(SECONDS_PER_MINUTE))
      else $error("seconds out of range");

   a_stopped_zero: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> seconds_ff == '0)
      else $error("seconds kept while stopped");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      advance && res_valid && (res_event == EV_TURN || res_event == EV_TARGET)
      |=> !running_ff && rivets_ff == '0 && !armed_ff)
      else $error("run not cleared after stop");

   a_total_only_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_event_ff != EV_TURN |-> rsp_total_ff == '0)
      else $error("rivet total given without full turn stop");

endmodule

// ===== rtl/rctc_debounce.sv =====
// sensor debounce: accepts a raw level after it held steady for a set tick count
// depends on rctc_pkg

module rctc_debounce (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               raw,
   input  logic [rctc_pkg::STEADY_WIDTH-1:0]  debounce_ticks,
   output logic                               clean_level
);
   import rctc_pkg::*;

   logic [STEADY_WIDTH-1:0] steady_ff, steady_in;
   logic                    raw_prev_ff;
   logic                    clean_ff, clean_in;
   logic [STEADY_WIDTH-1:0] steady_inc;

   assign steady_inc = steady_ff + 1'b1;

   always_comb begin
      steady_in = steady_ff;
      clean_in  = clean_ff;
      if (enable) begin
         if (raw == raw_prev_ff) begin
            steady_in = steady_inc;
            if (steady_inc == debounce_ticks) begin
               clean_in  = raw;
               steady_in = '0;
            end
         end else begin
            steady_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steady_ff   <= '0;
         raw_prev_ff <= 1'b1;
         clean_ff    <= 1'b1;
      end else begin
         steady_ff <= steady_in;
         clean_ff  <= clean_in;
         if (enable) begin
            raw_prev_ff <= raw;
         end
      end
   end

   // next value, so the tick that settles a level sees it at once
   assign clean_level = clean_in;

endmodule

// ===== rtl/rctc_frame.sv =====
// command frame buffer and decoder for received serial bytes
// depends on rctc_pkg

module rctc_frame #(
   parameter int unsigned FRAME_DEPTH = rctc_pkg::FRAME_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic [7:0]              rx_byte,
   output rctc_pkg::frame_cmd_type cmd
);
   import rctc_pkg::*;

   localparam int unsigned IDX_W = $clog2(FRAME_DEPTH);

   localparam logic [55:0] START_TEXT = "(START)";
   localparam logic [47:0] STOP_TEXT  = "(STOP)";
   localparam logic [23:0] MODE_TEXT  = "(M:";
   localparam logic [23:0] BATCH_TEXT = "(B:";
   localparam logic [7:0]  CHAR_ONE   = "1";
   localparam logic [7:0]  CHAR_TWO   = "2";

   logic [7:0]       frame_ff [FRAME_DEPTH];
   logic [7:0]       frame_in [FRAME_DEPTH];
   logic [7:0]       filled   [FRAME_DEPTH];
   logic [IDX_W-1:0] index_ff, index_in;
   logic [IDX_W-1:0] index_start;
   logic             is_start, is_stop, is_mode, is_batch;

   assign index_start = (rx_byte == CHAR_OPEN) ? '0 : index_ff;

   always_comb begin
      for (int i = 0; i < FRAME_DEPTH; i++) begin
         filled[i] = frame_ff[i];
      end
      filled[index_start] = rx_byte;
   end

   assign is_start = {filled[0], filled[1], filled[2], filled[3], filled[4], filled[5],
                      filled[6]} == START_TEXT;
   assign is_stop  = {filled[0], filled[1], filled[2], filled[3], filled[4],
                      filled[5]} == STOP_TEXT;
   assign is_mode  = ({filled[0], filled[1], filled[2]} == MODE_TEXT) &&
                     (filled[4] == CHAR_CLOSE);
   assign is_batch = ({filled[0], filled[1], filled[2]} == BATCH_TEXT) &&
                     (filled[4] == CHAR_CLOSE);

   always_comb begin
      cmd.done  = enable && (rx_byte == CHAR_CLOSE);
      cmd.digit = filled[3];
      if (is_start) begin
         cmd.code = CMD_START;
      end else if (is_stop) begin
         cmd.code = CMD_STOP;
      end else if (is_mode && filled[3] == CHAR_ONE) begin
         cmd.code = CMD_MODE1;
      end else if (is_mode && filled[3] == CHAR_TWO) begin
         cmd.code = CMD_MODE2;
      end else if (is_mode) begin
         cmd.code = CMD_ERROR;
      end else if (is_batch) begin
         cmd.code = CMD_TARGET;
      end else begin
         cmd.code = CMD_ERROR;
      end
   end

   always_comb begin
      for (int i = 0; i < FRAME_DEPTH; i++) begin
         frame_in[i] = frame_ff[i];
      end
      index_in = index_ff;
      if (enable) begin
         for (int i = 0; i < FRAME_DEPTH; i++) begin
            frame_in[i] = filled[i];
         end
         if (rx_byte == CHAR_CLOSE) begin
            frame_in[0] = '0;
            index_in    = '0;
         end else if (index_start == IDX_W'(FRAME_DEPTH - 1)) begin
            index_in = '0;
         end else begin
            index_in = index_start + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_DEPTH; i++) begin
            frame_ff[i] <= '0;
         end
         index_ff <= '0;
      end else begin
         for (int i = 0; i < FRAME_DEPTH; i++) begin
            frame_ff[i] <= frame_in[i];
         end
         index_ff <= index_in;
      end
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= IDX_W'(FRAME_DEPTH - 1))
      else $error("frame index beyond buffer");

   a_close_rewinds: assert property (@(posedge clock) disable iff (reset)
      enable && rx_byte == CHAR_CLOSE |=> index_ff == '0 && frame_ff[0] == '0)
      else $error("closing byte did not rewind frame");

   a_open_first: assert property (@(posedge clock) disable iff (reset)
      enable && rx_byte == CHAR_OPEN |=> frame_ff[0] == CHAR_OPEN && index_ff == IDX_W'(1))
      else $error("opening byte not stored first");

endmodule
